/* hw/rtl/lnts_pkg.sv */
`default_nettype none

package lnts_pkg;

  localparam int MAX_TERMS_DEFAULT = 128;
  localparam int FRAC_BITS_DEFAULT = 30;

  localparam int X_W   = 32;
  localparam int LN_W  = 32;
  localparam int TC_W  = 8;

  localparam int MUL_CHUNK_W = 16;
  localparam int DIV_RADIX_W = 8;

  localparam logic [TC_W-1:0] TERM_COUNT_RESET = 8'd99;

  typedef struct packed {
    logic load;
    logic mul_step;
    logic pow_load;
    logic div_step;
    logic acc_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic no_terms;
    logic term_last;
    logic out_free;
  } ctrl_status_t;

endpackage

`default_nettype wire

/* hw/rtl/lnts_ctrl.sv */
`default_nettype none

module lnts_ctrl #(
  parameter int FRAC_BITS = lnts_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire lnts_pkg::ctrl_status_t status,
  output lnts_pkg::ctrl_cmd_t        cmd
);

  localparam int PW        = FRAC_BITS + 8;
  localparam int XW        = FRAC_BITS + 2;
  localparam int MUL_STEPS = (XW + lnts_pkg::MUL_CHUNK_W - 1) / lnts_pkg::MUL_CHUNK_W;
  localparam int DIV_STEPS = (PW + lnts_pkg::DIV_RADIX_W - 1) / lnts_pkg::DIV_RADIX_W;
  localparam int STEPS_MAX = (MUL_STEPS > DIV_STEPS) ? MUL_STEPS : DIV_STEPS;
  localparam int SCW       = (STEPS_MAX > 1) ? $clog2(STEPS_MAX) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_POW,
    ST_DIV,
    ST_ACC,
    ST_OUT
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [SCW-1:0]   step_cnt;
  logic [SCW-1:0]   step_cnt_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load      = 1'b1;
          step_cnt_next = '0;
          state_next    = status.no_terms ? ST_OUT : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (step_cnt == SCW'(MUL_STEPS - 1)) begin
          step_cnt_next = '0;
          state_next    = ST_POW;
        end else begin
          step_cnt_next = step_cnt + 1'b1;
        end
      end
      ST_POW: begin
        cmd.pow_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_cnt == SCW'(DIV_STEPS - 1)) begin
          step_cnt_next = '0;
          state_next    = ST_ACC;
        end else begin
          step_cnt_next = step_cnt + 1'b1;
        end
      end
      ST_ACC: begin
        cmd.acc_step = 1'b1;
        state_next   = status.term_last ? ST_OUT : ST_MUL;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  a_mul_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (step_cnt <= SCW'(MUL_STEPS - 1)))
    else $error("multiply step counter out of range");

  a_out_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !status.out_free) |=> (state == ST_OUT))
    else $error("result dropped while output slot busy");

endmodule

`default_nettype wire

/* hw/rtl/lnts_datapath.sv */
`default_nettype none

module lnts_datapath #(
  parameter int MAX_TERMS = lnts_pkg::MAX_TERMS_DEFAULT,
  parameter int FRAC_BITS = lnts_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire lnts_pkg::ctrl_cmd_t          cmd,
  output lnts_pkg::ctrl_status_t            status,
  input  wire logic [lnts_pkg::TC_W-1:0]    term_count,
  input  wire logic [lnts_pkg::X_W-1:0]     x_value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [lnts_pkg::LN_W-1:0]  ln_value,
  output logic                              overflow
);

  localparam int F         = FRAC_BITS;
  localparam int CH        = lnts_pkg::MUL_CHUNK_W;
  localparam int R         = lnts_pkg::DIV_RADIX_W;
  localparam int PW        = F + 8;
  localparam int XW        = F + 2;
  localparam int AW        = F + 8;
  localparam int SW        = AW + 2;
  localparam int IW        = $clog2(MAX_TERMS + 1);
  localparam int CW        = (IW > lnts_pkg::TC_W) ? IW : lnts_pkg::TC_W;
  localparam int MUL_STEPS = (XW + CH - 1) / CH;
  localparam int MW        = MUL_STEPS * CH;
  localparam int PRW       = PW + MW;
  localparam int DIV_STEPS = (PW + R - 1) / R;
  localparam int DW        = DIV_STEPS * R;

  localparam logic [PW-1:0]        ONE_P   = {7'b0, 1'b1, {F{1'b0}}};
  localparam logic [XW-1:0]        ONE_X   = {2'b01, {F{1'b0}}};
  localparam logic [PW-1:0]        POW_MAX = {PW{1'b1}};
  localparam logic signed [SW-1:0] ACC_HI  = {3'b000, {(AW - 1){1'b1}}};
  localparam logic signed [SW-1:0] ACC_LO  = {3'b111, {(AW - 1){1'b0}}};

  logic [XW-1:0]          xf;
  logic                   x_neg;
  logic [XW-1:0]          x_mag;
  logic [CW-1:0]          tc_ext;
  logic [IW-1:0]          n_load;

  logic [MW-1:0]          dmag;
  logic                   dneg;
  logic [MW-1:0]          mshift;
  logic [PW-1:0]          pmag;
  logic                   pneg;
  logic [PRW-1:0]         prod;
  logic [IW-1:0]          term_idx;
  logic [IW-1:0]          n_terms;
  logic [DW-1:0]          div_q;
  logic [IW-1:0]          div_rem;
  logic signed [AW-1:0]   acc;
  logic                   ovf;

  logic [PW+CH-1:0]       mul_part;
  logic [PRW-1:0]         prod_next;
  logic                   pow_sat;
  logic [PW-1:0]          pow_next;
  logic [DW-1:0]          div_q_next;
  logic [IW-1:0]          div_rem_next;
  logic                   tneg;
  logic signed [SW-1:0]   acc_ext;
  logic signed [SW-1:0]   term_ext;
  logic signed [SW-1:0]   sum;
  logic signed [AW-1:0]   acc_next;
  logic                   acc_sat;
  logic [lnts_pkg::LN_W-1:0] res;

  if (F == 30) begin : g_x_same
    assign xf = x_value;
  end else if (F > 30) begin : g_x_widen
    assign xf = {x_value, {(F - 30){1'b0}}};
  end else begin : g_x_narrow
    assign xf = x_value[lnts_pkg::X_W-1:30-F];
  end

  if (F >= 24) begin : g_res_shift
    assign res = acc[F+7 -: lnts_pkg::LN_W];
  end else begin : g_res_scale
    assign res = {acc, {(24 - F){1'b0}}};
  end

  assign x_neg  = (xf < ONE_X);
  assign x_mag  = x_neg ? (ONE_X - xf) : (xf - ONE_X);
  assign tc_ext = CW'(term_count);
  assign n_load = (tc_ext > CW'(MAX_TERMS)) ? IW'(MAX_TERMS) : IW'(tc_ext);

  assign status.no_terms  = (term_count == '0);
  assign status.term_last = (term_idx == n_terms);
  assign status.out_free  = !out_valid || out_ready;

  assign mul_part  = (PW + CH)'(pmag) * (PW + CH)'(mshift[MW-1 -: CH]);
  assign prod_next = (prod << CH) + PRW'(mul_part);

  assign pow_sat  = (prod[PRW-1:F+PW] != '0);
  assign pow_next = pow_sat ? POW_MAX : prod[F+PW-1:F];

  always_comb begin
    logic [IW:0]   rem_w;
    logic [IW-1:0] rem_r;
    logic [DW-1:0] q_w;
    rem_r = div_rem;
    q_w   = div_q;
    rem_w = '0;
    for (int k = 0; k < R; k++) begin
      rem_w = {rem_r, q_w[DW-1]};
      q_w   = {q_w[DW-2:0], 1'b0};
      if (rem_w >= {1'b0, term_idx}) begin
        rem_w  = rem_w - {1'b0, term_idx};
        q_w[0] = 1'b1;
      end
      rem_r = rem_w[IW-1:0];
    end
    div_q_next   = q_w;
    div_rem_next = rem_r;
  end

  assign tneg     = pneg ^ ~term_idx[0];
  assign acc_ext  = {{2{acc[AW-1]}}, acc};
  assign term_ext = $signed({2'b00, div_q[PW-1:0]});
  assign sum      = tneg ? (acc_ext - term_ext) : (acc_ext + term_ext);

  always_comb begin
    acc_sat  = 1'b0;
    acc_next = sum[AW-1:0];
    if (sum > ACC_HI) begin
      acc_sat  = 1'b1;
      acc_next = ACC_HI[AW-1:0];
    end else if (sum < ACC_LO) begin
      acc_sat  = 1'b1;
      acc_next = ACC_LO[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dneg     <= x_neg;
      dmag     <= MW'(x_mag);
      mshift   <= MW'(x_mag);
      pmag     <= ONE_P;
      pneg     <= 1'b0;
      prod     <= '0;
      term_idx <= IW'(1);
      n_terms  <= n_load;
      acc      <= '0;
      ovf      <= 1'b0;
    end
    if (cmd.mul_step) begin
      prod   <= prod_next;
      mshift <= mshift << CH;
    end
    if (cmd.pow_load) begin
      pmag    <= pow_next;
      pneg    <= pneg ^ dneg;
      div_q   <= DW'(pow_next);
      div_rem <= '0;
      if (pow_sat) begin
        ovf <= 1'b1;
      end
    end
    if (cmd.div_step) begin
      div_q   <= div_q_next;
      div_rem <= div_rem_next;
    end
    if (cmd.acc_step) begin
      acc      <= acc_next;
      term_idx <= term_idx + 1'b1;
      prod     <= '0;
      mshift   <= dmag;
      if (acc_sat) begin
        ovf <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      ln_value <= res;
      overflow <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |=> (div_rem < term_idx))
    else $error("divider remainder not below divisor");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (acc == '0 && !ovf && term_idx == IW'(1)))
    else $error("series state not cleared on new argument");

endmodule

`default_nettype wire

/* hw/rtl/ln_taylor_series_evaluator.sv */
// Natural log by the Taylor series about 1: takes x in unsigned Q2.30 and returns
// sum over i = 1..term_count of (-1)^(i-1) (x-1)^i / i in signed Q8.24, with overflow
// raised if the running power or the sum saturated (the series converges only for
// 0 < x <= 2). term_count (reset 99, capped at MAX_TERMS) is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the block is idle, as
// the block itself does not enforce this. Each term forms the power 16 bits of
// (x-1) per cycle on one shared multiplier, then divides it by the term index 8
// quotient bits per cycle. When term_count is 0 no term is formed and the result
// is 0. A new argument is taken while the previous result still waits in the output
// register.
`default_nettype none

module ln_taylor_series_evaluator #(
  parameter int MAX_TERMS = lnts_pkg::MAX_TERMS_DEFAULT,
  parameter int FRAC_BITS = lnts_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [lnts_pkg::TC_W-1:0]    cfg_wr_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [lnts_pkg::X_W-1:0]     x_value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [lnts_pkg::LN_W-1:0]  ln_value,
  output logic                              overflow
);

  logic [lnts_pkg::TC_W-1:0] term_count;
  lnts_pkg::ctrl_cmd_t       cmd;
  lnts_pkg::ctrl_status_t    status;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= lnts_pkg::TERM_COUNT_RESET;
    end else if (cfg_wr_en) begin
      term_count <= cfg_wr_data;
    end
  end

  lnts_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lnts_datapath #(
    .MAX_TERMS (MAX_TERMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .term_count (term_count),
    .x_value    (x_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ln_value   (ln_value),
    .overflow   (overflow)
  );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = lnts_pkg::FRAC_BITS_DEFAULT;
  localparam int TERM_CAP = lnts_pkg::MAX_TERMS_DEFAULT;
  localparam logic [63:0] ONE_FX = 64'd1 << FRAC;
  localparam logic [63:0] POW_MAX = (64'd1 << (FRAC + 8)) - 64'd1;
  localparam logic signed [63:0] ACC_HI = (64'sd1 << (FRAC + 7)) - 64'sd1;
  localparam logic signed [63:0] ACC_LO = -ACC_HI - 64'sd1;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int RANDOM_ITEMS = 1400;

  typedef struct packed {
    logic signed [lnts_pkg::LN_W-1:0] ln;
    logic                             ovf;
  } ln_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_wr_en = 1'b0;
  logic [lnts_pkg::TC_W-1:0]       cfg_wr_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [lnts_pkg::X_W-1:0]        x_value = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic signed [lnts_pkg::LN_W-1:0] ln_value;
  logic                            overflow;

  ln_result_t                      ln_pending[$];
  logic [lnts_pkg::TC_W-1:0]       terms_now = lnts_pkg::TERM_COUNT_RESET;
  bit                              no_idle = 1'b0;
  int                              mismatches = 0;
  int                              cycles = 0;

  ln_taylor_series_evaluator i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .x_value    (x_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ln_value   (ln_value),
    .overflow   (overflow)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic ln_result_t ln_series(input logic [lnts_pkg::X_W-1:0] x,
                                           input logic [lnts_pkg::TC_W-1:0] tc);
    logic [63:0]        xf;
    logic [63:0]        dmag;
    logic [63:0]        pmag;
    logic [127:0]       prod;
    logic signed [63:0] acc;
    logic signed [63:0] t;
    logic               dneg;
    logic               pneg;
    logic               tneg;
    int                 n;
    int                 i;
    ln_result_t         r;
    xf = {32'd0, x} << (FRAC - 30);
    dneg = xf < ONE_FX;
    dmag = dneg ? ONE_FX - xf : xf - ONE_FX;
    n = (int'(tc) > TERM_CAP) ? TERM_CAP : int'(tc);
    pmag = ONE_FX;
    pneg = 1'b0;
    acc = '0;
    r.ovf = 1'b0;
    for (i = 1; i <= n; i++) begin
      prod = ({64'd0, pmag} * {64'd0, dmag}) >> FRAC;
      if (prod > {64'd0, POW_MAX}) begin
        pmag = POW_MAX;
        r.ovf = 1'b1;
      end else begin
        pmag = prod[63:0];
      end
      pneg = pneg ^ dneg;
      t = signed'(pmag / 64'(i));
      tneg = pneg ^ (i % 2 == 0);
      acc = tneg ? acc - t : acc + t;
      if (acc > ACC_HI) begin
        acc = ACC_HI;
        r.ovf = 1'b1;
      end else if (acc < ACC_LO) begin
        acc = ACC_LO;
        r.ovf = 1'b1;
      end
    end
    acc = acc >>> (FRAC - 24);
    r.ln = acc[lnts_pkg::LN_W-1:0];
    return r;
  endfunction

  function automatic int idle_cycles();
    return no_idle ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [lnts_pkg::X_W-1:0] random_x();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, 32'h8000_0000);
      5:             return 32'h4000_0000 + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      6:             return 32'h8000_0000 + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      7:             return $urandom_range(0, 255);
      default:       return $urandom;
    endcase
  endfunction

  task automatic send_x(input logic [lnts_pkg::X_W-1:0] x);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    x_value <= x;
    do @(posedge clk); while (!in_ready);
    ln_pending.push_back(ln_series(x, terms_now));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (ln_pending.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic set_terms(input logic [lnts_pkg::TC_W-1:0] tc);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= tc;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    terms_now = tc;
  endtask

  task automatic test_reset_terms();
    send_x(32'h0000_0000);
    send_x(32'h4000_0000);
    send_x(32'h8000_0000);
  endtask

  task automatic test_term_limits();
    set_terms(8'd0);
    send_x(32'hFFFF_FFFF);
    send_x(32'h1234_5678);
    set_terms(8'd1);
    send_x(32'h0000_0000);
    send_x(32'hFFFF_FFFF);
    set_terms(8'd255);
    send_x(32'h0000_0000);
    send_x(32'h6000_0000);
    send_x(32'hFFFF_FFFF);
    set_terms(8'd128);
    send_x(32'h8000_0000);
    send_x(32'h3FFF_FFFF);
    send_x(32'h4000_0001);
    send_x(32'h8000_0001);
  endtask

  task automatic test_edge_args();
    set_terms(8'd8);
    send_x(32'hC000_0000);
    send_x(32'hFFFF_FFFF);
    send_x(32'h0000_0001);
    send_x(32'h7FFF_FFFF);
    send_x(32'hAAAA_AAAA);
    send_x(32'h5555_5555);
  endtask

  task automatic test_hold_off();
    int k;
    set_terms(8'd5);
    no_idle = 1'b1;
    for (k = 0; k < 6; k++) send_x(random_x());
    drain();
    for (k = 0; k < 6; k++) send_x(random_x());
    no_idle = 1'b0;
  endtask

  task automatic test_random();
    int sent;
    int batch;
    int k;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0: begin
          set_terms(8'd0);
          batch = 20;
        end
        1: begin
          set_terms(8'($urandom_range(129, 255)));
          batch = 3;
        end
        2: begin
          set_terms(8'($urandom_range(17, 128)));
          batch = 4;
        end
        default: begin
          set_terms(8'($urandom_range(1, 16)));
          batch = 35;
        end
      endcase
      no_idle = ($urandom_range(0, 4) == 0);
      for (k = 0; k < batch; k++) send_x(random_x());
      sent += batch;
    end
    no_idle = 1'b0;
  endtask

  initial begin : result_check
    int stall;
    ln_result_t want;
    while (rst) @(posedge clk);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (ln_pending.size() == 0) begin
        $display("%0t: result with nothing pending, got ln_value %h overflow %b",
                 $time, ln_value, overflow);
        mismatches++;
      end else begin
        want = ln_pending.pop_front();
        if (ln_value !== want.ln) begin
          $display("%0t: ln_value expected %h got %h", $time, want.ln, ln_value);
          mismatches++;
        end
        if (overflow !== want.ovf) begin
          $display("%0t: overflow expected %b got %b", $time, want.ovf, overflow);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_terms();
    test_term_limits();
    test_edge_args();
    test_hold_off();
    test_random();
    drain();
    repeat (1200) @(posedge clk);
    if (mismatches == 0 && ln_pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
